FILE: hw/rtl/swfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_pkg
// Types and constants shared by the sliding window frame detector.
// ----------------------------------------------------------------------------
package swfd_pkg;

    localparam int WIN_LEN  = 13;
    localparam int SUM_LEN  = WIN_LEN - 1;
    localparam int FLAG_BIT = 7;

    typedef logic [7:0] byte_t;

    localparam byte_t SYNC_BYTE = 8'hA5;

    typedef struct packed {
        byte_t oldest;      // entry leaving the summed span
        byte_t entering;    // entry joining the summed span
        byte_t sync_cand;   // entry that becomes the new oldest
        byte_t flag_cand;   // entry that becomes the new second oldest
        byte_t checksum;    // incoming byte, the new checksum entry
    } check_in_t;

endpackage

FILE: hw/rtl/swfd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_in_if
// Byte request channel into the detector.
// ----------------------------------------------------------------------------
interface swfd_in_if;
    logic            valid;
    logic            ready;
    swfd_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/swfd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_out_if
// Frame request channel out of the detector.
// ----------------------------------------------------------------------------
interface swfd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] frame_first_bytes;
    logic [39:0] frame_last_bytes;

    modport source (output valid, output frame_first_bytes, output frame_last_bytes,
                    input ready);
    modport sink   (input valid, input frame_first_bytes, input frame_last_bytes,
                    output ready);
endinterface

FILE: hw/rtl/sliding_window_frame_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_frame_detector
// A frame is registered and shows on the output in the cycle after its last byte.
// Throughput: one byte per cycle; the single output register stalls input
// only while a frame waits and the sink holds ready low.
// Reset: window cells, running sum and output valid clear to zero.
// Bytes shift through a row of 13 cells; a running sum tracks the checksum.
// ----------------------------------------------------------------------------
module sliding_window_frame_detector
(
    input  logic       clk,
    input  logic       rst_n,
    swfd_in_if.sink    rx,
    swfd_out_if.source frame
);

    localparam int N = swfd_pkg::WIN_LEN;

    swfd_pkg::byte_t     win [N];
    swfd_pkg::byte_t     feed [N];
    logic                accept;
    logic                hit;
    swfd_pkg::check_in_t chk;

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] first_reg;
    logic [39:0] last_reg;

    assign rx.ready = !valid_reg || frame.ready;
    assign accept   = rx.valid && rx.ready;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            if (i == N - 1)
            begin : g_tail
                assign feed[i] = rx.rx_byte;
            end
            else
            begin : g_body
                assign feed[i] = win[i + 1];
            end

            swfd_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (accept),
                .din   (feed[i]),
                .dout  (win[i])
            );
        end
    endgenerate

    assign chk.oldest    = win[0];
    assign chk.entering  = win[N - 1];
    assign chk.sync_cand = win[1];
    assign chk.flag_cand = win[2];
    assign chk.checksum  = rx.rx_byte;

    swfd_check u_check
    (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (accept),
        .chk   (chk),
        .hit   (hit)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (frame.ready)
        begin
            valid_next = 1'b0;
        end
        if (accept && hit)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the frame as the window stands after the shift
    always_ff @(posedge clk)
    begin
        if (accept && hit)
        begin
            first_reg <= {win[8], win[7], win[6], win[5],
                          win[4], win[3], win[2], win[1]};
            last_reg  <= {rx.rx_byte, win[12], win[11], win[10], win[9]};
        end
    end

    assign frame.valid             = valid_reg;
    assign frame.frame_first_bytes = first_reg;
    assign frame.frame_last_bytes  = last_reg;

endmodule

FILE: hw/rtl/swfd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_cell
// One window entry: loads the byte of its younger neighbor on each shift.
// ----------------------------------------------------------------------------
module swfd_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  swfd_pkg::byte_t din,
    output swfd_pkg::byte_t dout
);

    swfd_pkg::byte_t data_reg;
    swfd_pkg::byte_t data_next;

    assign data_next = shift ? din : data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

FILE: hw/rtl/swfd_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_check
// Running 8-bit sum over the oldest twelve entries and the frame test.
// ----------------------------------------------------------------------------
module swfd_check
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  swfd_pkg::check_in_t chk,
    output logic                hit
);

    swfd_pkg::byte_t sum_reg;
    swfd_pkg::byte_t sum_next;

    // drop the leaving entry, add the one that slides in
    assign sum_next = shift ? (sum_reg - chk.oldest + chk.entering) : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    // test the window as it stands after this shift
    assign hit = (chk.sync_cand == swfd_pkg::SYNC_BYTE)
              && !chk.flag_cand[swfd_pkg::FLAG_BIT]
              && ((sum_reg - chk.oldest + chk.entering) == chk.checksum);

endmodule
